[rtl/rrst_pkg.sv]
package rrst_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam int REQ_W  = 2;
  localparam int SLOT_W = 3;
  localparam int TICK_W = 32;

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;  // capture the accepted request
    logic lookup;    // pick the ring slot to scan and read its timing
    logic commit;    // apply the request and load the result register
  } dp_cmd_t;

endpackage

[rtl/rrst_ram.sv]
module rrst_ram
  import rrst_pkg::*;
#(
  parameter int WIDTH = TICK_W,
  parameter int DEPTH = NUM_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rrst_ctrl.sv]
module rrst_ctrl
  import rrst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // hold the finished request until the result register frees up
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.latch_in = 1'b0;
    cmd.lookup   = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_EVAL: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/rrst_dp.sv]
module rrst_dp
  import rrst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [SLOT_W-1:0] in_timer_slot,
  input  logic [TICK_W-1:0] in_interval_ticks,
  input  logic              in_periodic,
  input  logic [TICK_W-1:0] in_now_tick,
  output logic              out_status,
  output logic              out_fired,
  output logic [SLOT_W-1:0] out_fired_slot
);

  localparam int SIDX_W = $clog2(NUM_SLOTS);
  localparam int XW     = (SIDX_W > SLOT_W) ? SIDX_W : SLOT_W;

  // lowest ring slot at or after 'from', else the lowest overall; top bit = found
  function automatic logic [SIDX_W:0] ring_first(input logic [NUM_SLOTS-1:0] ring,
                                                 input logic [SIDX_W-1:0]    from);
    logic [SIDX_W-1:0] hi_idx;
    logic [SIDX_W-1:0] lo_idx;
    logic              hi_hit;
    logic              lo_hit;
    hi_idx = '0;
    lo_idx = '0;
    hi_hit = 1'b0;
    lo_hit = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (ring[i]) begin
        lo_idx = SIDX_W'(i);
        lo_hit = 1'b1;
        if (SIDX_W'(i) >= from) begin
          hi_idx = SIDX_W'(i);
          hi_hit = 1'b1;
        end
      end
    end
    return hi_hit ? {1'b1, hi_idx} : {lo_hit, lo_idx};
  endfunction

  // latched request
  logic [REQ_W-1:0]  req_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TICK_W-1:0] interval_r;
  logic              per_r;
  logic [TICK_W-1:0] now_r;

  // slot state
  logic [NUM_SLOTS-1:0] in_ring_r, in_ring_nxt;
  logic [NUM_SLOTS-1:0] enabled_r, enabled_nxt;
  logic [NUM_SLOTS-1:0] periodic_r, periodic_nxt;
  logic [SIDX_W-1:0]    scan_ptr_r, scan_ptr_nxt;
  logic [SIDX_W-1:0]    cur_r;
  logic                 cur_hit_r;

  // result register
  logic              status_r, status_nxt;
  logic              fired_r, fired_nxt;
  logic [SLOT_W-1:0] fslot_r, fslot_nxt;

  logic [SIDX_W:0]   cur_search;
  logic [SIDX_W:0]   next_search;
  logic [SIDX_W:0]   cur_inc;
  logic [SIDX_W-1:0] cur_wrap;
  logic [XW-1:0]     slot_x;
  logic [XW-1:0]     cur_x;
  logic [SIDX_W-1:0] slot_idx;
  logic              slot_in_range;

  logic [TICK_W-1:0] period_q;
  logic [TICK_W-1:0] base_q;
  logic [TICK_W-1:0] elapsed;
  logic              expired;

  logic              period_we;
  logic              base_we;
  logic [SIDX_W-1:0] waddr;
  logic [TICK_W-1:0] base_wdata;

  assign slot_x        = XW'(slot_r);
  assign slot_idx      = slot_x[SIDX_W-1:0];
  assign slot_in_range = 32'(slot_r) < 32'(NUM_SLOTS);

  assign cur_search  = ring_first(in_ring_r, scan_ptr_r);
  assign cur_inc     = {1'b0, cur_r} + {{SIDX_W{1'b0}}, 1'b1};
  assign cur_wrap    = (cur_inc == (SIDX_W + 1)'(NUM_SLOTS)) ? '0 : cur_inc[SIDX_W-1:0];
  assign next_search = ring_first(in_ring_r, cur_wrap);
  assign cur_x       = XW'(cur_r);

  assign elapsed = now_r - base_q;
  assign expired = cur_hit_r && enabled_r[cur_r] && (elapsed >= period_q);

  always_comb begin
    in_ring_nxt  = in_ring_r;
    enabled_nxt  = enabled_r;
    periodic_nxt = periodic_r;
    scan_ptr_nxt = scan_ptr_r;
    status_nxt   = status_r;
    fired_nxt    = fired_r;
    fslot_nxt    = fslot_r;
    period_we    = 1'b0;
    base_we      = 1'b0;
    waddr        = slot_idx;
    base_wdata   = now_r;
    if (cmd.commit) begin
      status_nxt = 1'b0;
      fired_nxt  = 1'b0;
      fslot_nxt  = '0;
      unique case (req_r)
        REQ_START: begin
          if (slot_in_range) begin
            in_ring_nxt[slot_idx]  = 1'b1;
            enabled_nxt[slot_idx]  = 1'b1;
            periodic_nxt[slot_idx] = per_r;
            period_we              = 1'b1;
            base_we                = 1'b1;
          end
        end
        REQ_STOP: begin
          if (slot_in_range && in_ring_r[slot_idx]) begin
            enabled_nxt[slot_idx] = 1'b0;
          end else begin
            status_nxt = 1'b1;
          end
        end
        REQ_TICK: begin
          waddr      = cur_r;
          base_wdata = base_q + period_q;
          if (expired) begin
            fired_nxt = 1'b1;
            fslot_nxt = cur_x[SLOT_W-1:0];
            base_we   = 1'b1;
            if (!periodic_r[cur_r]) enabled_nxt[cur_r] = 1'b0;
          end
          if (cur_hit_r) scan_ptr_nxt = next_search[SIDX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ring_r  <= '0;
      enabled_r  <= '0;
      periodic_r <= '0;
      scan_ptr_r <= '0;
    end else begin
      in_ring_r  <= in_ring_nxt;
      enabled_r  <= enabled_nxt;
      periodic_r <= periodic_nxt;
      scan_ptr_r <= scan_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r      <= in_req_type;
      slot_r     <= in_timer_slot;
      interval_r <= in_interval_ticks;
      per_r      <= in_periodic;
      now_r      <= in_now_tick;
    end
    if (cmd.lookup) begin
      cur_r     <= cur_search[SIDX_W-1:0];
      cur_hit_r <= cur_search[SIDX_W];
    end
    status_r <= status_nxt;
    fired_r  <= fired_nxt;
    fslot_r  <= fslot_nxt;
  end

  // timing words are read at the slot picked in the lookup cycle
  rrst_ram #(
    .WIDTH (TICK_W),
    .DEPTH (NUM_SLOTS)
  ) u_period_ram (
    .clk   (clk),
    .we    (period_we),
    .waddr (waddr),
    .wdata (interval_r),
    .raddr (cur_search[SIDX_W-1:0]),
    .rdata (period_q)
  );

  rrst_ram #(
    .WIDTH (TICK_W),
    .DEPTH (NUM_SLOTS)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (waddr),
    .wdata (base_wdata),
    .raddr (cur_search[SIDX_W-1:0]),
    .rdata (base_q)
  );

  assign out_status     = status_r;
  assign out_fired      = fired_r;
  assign out_fired_slot = fslot_r;

endmodule

[rtl/round_robin_soft_timer_table.sv]
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_ready  | req_type, timer_slot, interval_ticks,
//          |                      | periodic, now_tick
// result   | out_valid / out_ready| status, fired, fired_slot
//
// Requests are handled one at a time: accept, slot lookup with the timing RAM
// read, then evaluate and load the result register.
// A new request is taken while the previous result waits; the evaluate step
// holds until the result register is free.
// Synchronous active-low reset empties the ring, disables all slots and
// zeroes the scan pointer; the timing RAMs are not reset, a start writes them.
module round_robin_soft_timer_table
  import rrst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [SLOT_W-1:0] in_timer_slot,
  input  logic [TICK_W-1:0] in_interval_ticks,
  input  logic              in_periodic,
  input  logic [TICK_W-1:0] in_now_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic              out_fired,
  output logic [SLOT_W-1:0] out_fired_slot
);

  dp_cmd_t cmd;

  rrst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rrst_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_timer_slot     (in_timer_slot),
    .in_interval_ticks (in_interval_ticks),
    .in_periodic       (in_periodic),
    .in_now_tick       (in_now_tick),
    .out_status        (out_status),
    .out_fired         (out_fired),
    .out_fired_slot    (out_fired_slot)
  );

endmodule

[test/round_robin_soft_timer_table_test.sv]
`timescale 1ns / 1ps

module round_robin_soft_timer_table_test;
  import rrst_pkg::*;

  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] interval;
    logic              periodic;
    logic [TICK_W-1:0] now;
  } timer_req_t;

  typedef struct packed {
    logic              status;
    logic              fired;
    logic [SLOT_W-1:0] fired_slot;
  } timer_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [SLOT_W-1:0] in_timer_slot = '0;
  logic [TICK_W-1:0] in_interval_ticks = '0;
  logic              in_periodic = 1'b0;
  logic [TICK_W-1:0] in_now_tick = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_status;
  logic              out_fired;
  logic [SLOT_W-1:0] out_fired_slot;

  round_robin_soft_timer_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_timer_slot    (in_timer_slot),
    .in_interval_ticks(in_interval_ticks),
    .in_periodic      (in_periodic),
    .in_now_tick      (in_now_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_fired        (out_fired),
    .out_fired_slot   (out_fired_slot)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  timer_req_t  pending_requests[$];
  timer_resp_t expected_responses[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  bit          hold_arm = 1'b0;
  bit          hold_used = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [TICK_W-1:0] sys_tick;

  // shadow timer table
  logic              slot_in_ring[NUM_SLOTS];
  logic              slot_armed[NUM_SLOTS];
  logic              slot_reload[NUM_SLOTS];
  logic [TICK_W-1:0] slot_span[NUM_SLOTS];
  logic [TICK_W-1:0] slot_origin[NUM_SLOTS];
  int                scan_pos = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_in_ring[i] = 1'b0;
      slot_armed[i]   = 1'b0;
      slot_reload[i]  = 1'b0;
      slot_span[i]    = '0;
      slot_origin[i]  = '0;
    end
  end

  // first ring slot at or after 'from', cyclic; NUM_SLOTS when ring empty
  function automatic int next_ring_slot(int from);
    int s;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = (from + k) % NUM_SLOTS;
      if (slot_in_ring[s]) return s;
    end
    return NUM_SLOTS;
  endfunction

  function automatic timer_resp_t predict_timer_response(timer_req_t r);
    timer_resp_t       resp;
    int                cur;
    logic [TICK_W-1:0] elapsed;
    resp = '0;
    case (r.kind)
      REQ_START: begin
        if (r.slot < NUM_SLOTS) begin
          slot_span[r.slot]    = r.interval;
          slot_reload[r.slot]  = r.periodic;
          slot_origin[r.slot]  = r.now;
          slot_armed[r.slot]   = 1'b1;
          slot_in_ring[r.slot] = 1'b1;
        end
      end
      REQ_STOP: begin
        if (r.slot < NUM_SLOTS && slot_in_ring[r.slot]) slot_armed[r.slot] = 1'b0;
        else resp.status = 1'b1;
      end
      REQ_TICK: begin
        cur = next_ring_slot(scan_pos % NUM_SLOTS);
        if (cur < NUM_SLOTS) begin
          elapsed = r.now - slot_origin[cur];
          if (slot_armed[cur] && elapsed >= slot_span[cur]) begin
            resp.fired      = 1'b1;
            resp.fired_slot = cur[SLOT_W-1:0];
            slot_origin[cur] = slot_origin[cur] + slot_span[cur];
            if (!slot_reload[cur]) slot_armed[cur] = 1'b0;
          end
          scan_pos = next_ring_slot((cur + 1) % NUM_SLOTS);
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic push_req(logic [REQ_W-1:0] kind, logic [SLOT_W-1:0] slot,
                          logic [TICK_W-1:0] interval, logic periodic,
                          logic [TICK_W-1:0] now);
    timer_req_t r;
    r.kind     = kind;
    r.slot     = slot;
    r.interval = interval;
    r.periodic = periodic;
    r.now      = now;
    pending_requests.push_back(r);
  endtask

  // mostly a coherent tick stream with short intervals, some noise
  task automatic queue_random_requests(int count);
    int          roll;
    int          pick;
    logic [31:0] iv;
    sys_tick = $urandom();
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        if ($urandom_range(19) == 0) sys_tick = sys_tick + $urandom_range(40);
        else sys_tick = sys_tick + $urandom_range(4);
        push_req(REQ_TICK, SLOT_W'($urandom()), $urandom(), 1'($urandom()), sys_tick);
      end else if (roll < 75) begin
        pick = $urandom_range(9);
        if (pick == 0) iv = $urandom();
        else if (pick == 1) iv = '0;
        else iv = $urandom_range(12);
        push_req(REQ_START, SLOT_W'($urandom()), iv, 1'($urandom()), sys_tick);
      end else if (roll < 90) begin
        push_req(REQ_STOP, SLOT_W'($urandom()), $urandom(), 1'($urandom()), $urandom());
      end else begin
        push_req(REQ_W'($urandom()), SLOT_W'($urandom()), $urandom(), 1'($urandom()),
                 $urandom());
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive
    timer_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_requests.pop_front();
        in_req_type       <= nxt.kind;
        in_timer_slot     <= nxt.slot;
        in_interval_ticks <= nxt.interval;
        in_periodic       <= nxt.periodic;
        in_now_tick       <= nxt.now;
        in_valid          <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
  end

  // monitor: predict on request acceptance, check on result acceptance
  always @(posedge clk) begin : monitor
    timer_req_t  req;
    timer_resp_t exp_resp;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req.kind     = in_req_type;
        req.slot     = in_timer_slot;
        req.interval = in_interval_ticks;
        req.periodic = in_periodic;
        req.now      = in_now_tick;
        expected_responses.push_back(predict_timer_response(req));
      end
      if (out_valid && out_ready) begin
        if (expected_responses.size() == 0) begin
          $error("result with nothing expected: status %0d fired %0d fired_slot %0d",
                 out_status, out_fired, out_fired_slot);
          mismatches++;
        end else begin
          exp_resp = expected_responses.pop_front();
          if (out_status !== exp_resp.status) begin
            $error("status: expected %0d, got %0d", exp_resp.status, out_status);
            mismatches++;
          end
          if (out_fired !== exp_resp.fired) begin
            $error("fired: expected %0d, got %0d", exp_resp.fired, out_fired);
            mismatches++;
          end
          if (out_fired_slot !== exp_resp.fired_slot) begin
            $error("fired_slot: expected %0d, got %0d", exp_resp.fired_slot,
                   out_fired_slot);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("round_robin_soft_timer_table_test: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct   = 19;
    receiver_idle_pct = 67;

    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd0);       // empty ring
    push_req(REQ_STOP,  3'd5, '1, 1'b1, '1);             // never started
    push_req(REQ_SPARE, 3'd7, '1, 1'b1, '1);             // unused code
    push_req(REQ_START, 3'd2, 32'd0, 1'b1, 32'd100);     // zero interval
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd100);
    push_req(REQ_START, 3'd6, 32'd3, 1'b0, 32'd100);     // one-shot
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd101);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd102);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd103);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd104);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd200);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd300);     // one-shot spent
    push_req(REQ_STOP,  3'd2, 32'd0, 1'b0, 32'd0);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd301);     // stopped slot scanned
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd302);
    push_req(REQ_START, 3'd2, '1, 1'b1, 32'hFFFF_FFF0);  // restart, max interval
    push_req(REQ_START, 3'd7, 32'h10, 1'b0, 32'hFFFF_FFF8);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'h0000_0008); // wraps past zero
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'h0000_0008);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'hFFFF_FFEF);
    push_req(REQ_START, 3'd0, 32'd5, 1'b1, 32'd0);       // behind the pointer
    push_req(REQ_START, 3'd4, 32'd1, 1'b0, 32'd0);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd10);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, 32'd10);
    push_req(REQ_TICK,  3'd0, 32'd0, 1'b0, '1);
    queue_random_requests(260);
    wait_drained();

    sender_idle_pct   = 67;
    receiver_idle_pct = 19;
    queue_random_requests(280);
    wait_drained();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_arm = 1'b1;
    queue_random_requests(290);
    wait_drained();

    repeat (12) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d results never arrived", expected_responses.size());
      mismatches++;
    end
    if (mismatches == 0) $display("round_robin_soft_timer_table_test: clean");
    else $display("round_robin_soft_timer_table_test: errors");
    $finish;
  end

endmodule
